FILE: sv/stwt_pkg.sv
// ----------------------------------------------------------------------------
// stwt_pkg: shared types and constants for the sleep timer wakeup table
// Slot geometry, status codes, sequencer states and the reciprocal constants
// used to divide by the fixed scale factors of the delay computation.
// ----------------------------------------------------------------------------
`default_nettype none

package stwt_pkg;

    // table geometry
    localparam int SLOTS   = 16;
    localparam int ID_BITS = 8;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // stream payload widths
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 8;
    localparam int STATUS_W   = 3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_QUEUED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOWAIT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WOKEN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDLE   = 3'd4;

    // register map (index taken from paddr[2])
    localparam logic IDX_FREQ = 1'b0;
    localparam logic [31:0] FREQ_RESET = 32'd10000000;

    // reciprocals, rounded up, for exact floor division
    // freq/100000  = (freq>>5)*RECIP_F >> 39   (27-bit operand)
    // nsec/10000   = (nsec>>4)*RECIP_A >> 36   (26-bit operand)
    // v/10000      = (v>>4)*RECIP_B    >> 35   (26-bit operand, v < 2^29)
    localparam logic [63:0] RECIP_F_W = ((64'd1 << 39) + 64'd3124) / 64'd3125;
    localparam logic [63:0] RECIP_A_W = ((64'd1 << 36) + 64'd624) / 64'd625;
    localparam logic [63:0] RECIP_B_W = ((64'd1 << 35) + 64'd624) / 64'd625;
    localparam logic [27:0] RECIP_F = RECIP_F_W[27:0];
    localparam logic [26:0] RECIP_A = RECIP_A_W[26:0];
    localparam logic [25:0] RECIP_B = RECIP_B_W[25:0];
    localparam logic [29:0] TEN_THOUSAND = 30'd10000;

    // one table entry
    typedef struct packed {
        logic [ID_BITS-1:0] task_id;
        logic [63:0]        expiry;
    } slot_t;

    // sequencer states
    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_MUL_A  = 10'b00_0000_0010,
        S_MUL_B  = 10'b00_0000_0100,
        S_MUL_C  = 10'b00_0000_1000,
        S_MUL_D  = 10'b00_0001_0000,
        S_ADD_Q  = 10'b00_0010_0000,
        S_ADD_N  = 10'b00_0100_0000,
        S_DECIDE = 10'b00_1000_0000,
        S_SCAN   = 10'b01_0000_0000,
        S_FINISH = 10'b10_0000_0000
    } state_t;

endpackage

`default_nettype wire

FILE: sv/sleep_timer_wakeup_table.sv
// ----------------------------------------------------------------------------
// sleep_timer_wakeup_table: table of sleeping tasks with absolute expiry ticks
// Sleep request: delay states S_MUL_A to S_ADD_N, then S_DECIDE loads the output register.
// Tick check: one slot read per cycle from the slot memory while the output does not
// stall; one word per woken task, or one nothing-due word.
// One item is in work at a time; a new item is taken while a result waits.
// Reset clears busy bits and sets ticks_per_second to 10000000; slot memory
// contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sleep_timer_wakeup_table (
    input  logic                               clk,
    input  logic                               rst_n,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: task_id[7:0], req_seconds[39:8], req_nanoseconds[69:40],
    //        now_ticks[133:70], zero pad[135:134]
    input  logic [stwt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: kind (0 sleep request, 1 tick check)
    input  logic                               s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: woken_id[7:0]
    output logic [stwt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: status[2:0]
    output logic [stwt_pkg::STATUS_W-1:0]      m_axis_tuser,
    output logic                               m_axis_tlast,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import stwt_pkg::*;

    localparam logic [SLOT_W:0] SLOTS_CNT = (SLOT_W+1)'(SLOTS);

    // control registers
    state_t             state_reg, state_next;
    logic [SLOTS-1:0]   busy_reg, busy_next;
    logic [SLOT_W:0]    scan_idx_reg, scan_idx_next;
    logic               proc_valid_reg, proc_valid_next;
    logic [SLOT_W-1:0]  proc_idx_reg, proc_idx_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        freq_reg;

    // payload registers
    logic [ID_BITS-1:0] id_reg;
    logic [31:0]        sec_reg;
    logic [29:0]        nsec_reg;
    logic [63:0]        now_reg;
    logic [15:0]        per_reg;
    logic [16:0]        a_reg;
    logic [13:0]        b_reg;
    logic [63:0]        sf_reg;
    logic [32:0]        ap_reg;
    logic [29:0]        bp_reg;
    logic [16:0]        q_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        expiry_reg;
    logic [ID_BITS-1:0] pend_id_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [OUT_DATA_W-1:0] out_id_reg;
    logic               out_last_reg;
    slot_t              rd_data_reg;

    // slot memory
    slot_t              slot_mem [SLOTS];

    // combinational signals
    logic               accept;
    logic               cfg_we;
    logic               out_free;
    logic [54:0]        per_prod;
    logic [52:0]        a_prod;
    logic [29:0]        a_times;
    logic [29:0]        b_diff;
    logic [51:0]        q_prod;
    logic               no_wait;
    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic               due;
    logic               stall;
    logic               issue;
    logic               rd_en;
    logic               mem_we;
    logic               pend_load;
    logic               out_load;
    logic [STATUS_W-1:0] out_status_next;
    logic [OUT_DATA_W-1:0] out_id_next;
    logic               out_last_next;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_id_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == IDX_FREQ);
    assign prdata = (paddr[2] == IDX_FREQ) ? freq_reg : 32'd0;

    // delay arithmetic, one multiplier per path
    always_comb
    begin
        per_prod = 55'(freq_reg[31:5]) * 55'(RECIP_F);
        a_prod   = 53'(nsec_reg[29:4]) * 53'(RECIP_A);
        a_times  = 30'(a_reg) * TEN_THOUSAND;
        b_diff   = nsec_reg - a_times;
        q_prod   = 52'(bp_reg[29:4]) * 52'(RECIP_B);
        no_wait  = !(now_reg < expiry_reg);
    end

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // scan check on the slot word held in the read register
    assign due   = proc_valid_reg && busy_reg[proc_idx_reg] &&
                   (rd_data_reg.expiry <= now_reg);
    assign stall = due && pend_valid_reg && !out_free;
    assign issue = (scan_idx_reg != SLOTS_CNT);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        scan_idx_next   = scan_idx_reg;
        proc_valid_next = proc_valid_reg;
        proc_idx_next   = proc_idx_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        rd_en           = 1'b0;
        mem_we          = 1'b0;
        pend_load       = 1'b0;
        out_load        = 1'b0;
        out_status_next = ST_IDLE;
        out_id_next     = '0;
        out_last_next   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    if (s_axis_tuser) begin
                        state_next      = S_SCAN;
                        scan_idx_next   = '0;
                        proc_valid_next = 1'b0;
                        pend_valid_next = 1'b0;
                    end else begin
                        state_next = S_MUL_A;
                    end
                end
            end
            S_MUL_A: state_next = S_MUL_B;
            S_MUL_B: state_next = S_MUL_C;
            S_MUL_C: state_next = S_MUL_D;
            S_MUL_D: state_next = S_ADD_Q;
            S_ADD_Q: state_next = S_ADD_N;
            S_ADD_N: state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (no_wait) begin
                        out_status_next = ST_NOWAIT;
                    end else if (free_found) begin
                        out_status_next     = ST_QUEUED;
                        out_id_next         = OUT_DATA_W'(id_reg);
                        mem_we              = 1'b1;
                        busy_next[free_idx] = 1'b1;
                    end else begin
                        out_status_next = ST_FULL;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (!stall) begin
                    rd_en           = issue;
                    scan_idx_next   = issue ? scan_idx_reg + (SLOT_W+1)'(1) : scan_idx_reg;
                    proc_valid_next = issue;
                    proc_idx_next   = scan_idx_reg[SLOT_W-1:0];
                    // a due slot replaces the held word, which goes out
                    if (due) begin
                        busy_next[proc_idx_reg] = 1'b0;
                        pend_load               = 1'b1;
                        pend_valid_next         = 1'b1;
                        if (pend_valid_reg) begin
                            out_load        = 1'b1;
                            out_status_next = ST_WOKEN;
                            out_id_next     = OUT_DATA_W'(pend_id_reg);
                            out_last_next   = 1'b0;
                        end
                    end
                    if (!issue) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (pend_valid_reg) begin
                        out_status_next = ST_WOKEN;
                        out_id_next     = OUT_DATA_W'(pend_id_reg);
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            busy_reg       <= '0;
            scan_idx_reg   <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            freq_reg       <= FREQ_RESET;
        end else begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            scan_idx_reg   <= scan_idx_next;
            proc_valid_reg <= proc_valid_next;
            proc_idx_reg   <= proc_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we) begin
                freq_reg <= pwdata;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept) begin
            id_reg   <= ID_BITS'(s_axis_tdata[7:0]);
            sec_reg  <= s_axis_tdata[39:8];
            nsec_reg <= s_axis_tdata[69:40];
            now_reg  <= s_axis_tdata[133:70];
        end
        case (state_reg)
            S_MUL_A:
            begin
                per_reg <= per_prod[54:39];
                a_reg   <= a_prod[52:36];
            end
            S_MUL_B:
            begin
                b_reg  <= b_diff[13:0];
                sf_reg <= 64'(sec_reg) * 64'(freq_reg);
            end
            S_MUL_C:
            begin
                ap_reg <= 33'(a_reg) * 33'(per_reg);
                bp_reg <= 30'(b_reg) * 30'(per_reg);
            end
            S_MUL_D:
            begin
                q_reg   <= q_prod[51:35];
                sum_reg <= sf_reg + 64'(ap_reg);
            end
            S_ADD_Q: sum_reg    <= sum_reg + 64'(q_reg);
            S_ADD_N: expiry_reg <= now_reg + sum_reg;
            default: ;
        endcase
        if (pend_load) begin
            pend_id_reg <= rd_data_reg.task_id;
        end
        if (out_load) begin
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_last_reg   <= out_last_next;
        end
    end

    // slot memory, one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            slot_mem[free_idx] <= '{task_id: id_reg, expiry: expiry_reg};
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem[scan_idx_reg[SLOT_W-1:0]];
        end
    end

`ifndef SYNTH
    // a slot is only written while free
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !busy_reg[free_idx])
        else $error("slot write to a busy slot");

    // a written slot is busy afterwards
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> busy_reg[$past(free_idx)])
        else $error("written slot not marked busy");

    // at most one slot is taken per cycle
    a_busy_step: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_reg) <= $past($countones(busy_reg)) + 1)
        else $error("more than one slot taken in a cycle");

    // no word is loaded while the output holds a word not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output word overwritten");
`endif

endmodule

`default_nettype wire

FILE: sim/sleep_timer_wakeup_table_test.sv
// ----------------------------------------------------------------------------
// sleep_timer_wakeup_table_test: self-checking bench for the wakeup table
// Drives sleep requests and tick checks on the request stream and keeps a
// shadow copy of the slot table and the tick rate. Every item is predicted
// when it is sent, and each word on the result stream is compared in order.
// Runs directed corner cases, sweeps the tick rate, then three random phases
// with different stall patterns on both streams.
// ----------------------------------------------------------------------------
module sleep_timer_wakeup_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stwt_pkg::*;

    localparam logic KIND_SLEEP = 1'b0;
    localparam logic KIND_TICK  = 1'b1;
    localparam logic IDX_UNUSED = 1'b1;
    localparam int   WATCHDOG_LIMIT = 4000;

    // one expected result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          id;
        logic                last;
    } outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // shadow of the block state
    bit                     slot_used [SLOTS];
    logic [7:0]             slot_task_id [SLOTS];
    logic [63:0]            slot_due [SLOTS];
    logic [31:0]            tick_rate = FREQ_RESET;

    outcome_t               outcome_q[$];
    logic [63:0]            task_clock = '0;
    int                     src_gap_pct = 0;
    int                     sink_stall_pct = 0;
    int                     errors = 0;
    int                     idle_cycles = 0;

    sleep_timer_wakeup_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ticks to wait for a sleep of sec seconds plus nsec nanoseconds
    function automatic logic [63:0] sleep_ticks(input logic [31:0] sec,
                                                input logic [29:0] nsec);
        logic [63:0] per_10us;
        per_10us = {32'd0, tick_rate} / 64'd100000;
        return {32'd0, sec} * {32'd0, tick_rate} + ({34'd0, nsec} * per_10us) / 64'd10000;
    endfunction

    function automatic void note_outcome(input logic [STATUS_W-1:0] status,
                                         input logic [7:0] id, input logic last);
        outcome_t o;
        o.status = status;
        o.id     = id;
        o.last   = last;
        outcome_q.push_back(o);
    endfunction

    // update the shadow table and queue the words this item must produce
    function automatic void predict_item(input logic kind, input logic [7:0] id,
                                         input logic [31:0] sec, input logic [29:0] nsec,
                                         input logic [63:0] now);
        logic [63:0] due;
        int          woken;
        bit          placed;
        outcome_t    tail;
        woken  = 0;
        placed = 0;
        if (kind == KIND_SLEEP)
        begin
            due = now + sleep_ticks(sec, nsec);
            if (!(now < due))
                note_outcome(ST_NOWAIT, 8'd0, 1'b1);
            else
            begin
                // lowest free slot wins
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!placed && !slot_used[i])
                    begin
                        slot_used[i]    = 1'b1;
                        slot_task_id[i] = id;
                        slot_due[i]     = due;
                        placed          = 1;
                    end
                end
                if (placed)
                    note_outcome(ST_QUEUED, id, 1'b1);
                else
                    note_outcome(ST_FULL, 8'd0, 1'b1);
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_used[i] && slot_due[i] <= now)
                begin
                    slot_used[i] = 1'b0;
                    note_outcome(ST_WOKEN, slot_task_id[i], 1'b0);
                    woken++;
                end
            end
            if (woken == 0)
                note_outcome(ST_IDLE, 8'd0, 1'b1);
            else
            begin
                tail = outcome_q.pop_back();
                tail.last = 1'b1;
                outcome_q.push_back(tail);
            end
        end
    endfunction

    // send one request word, with random gaps ahead of it
    task automatic send_item(input logic kind, input logic [7:0] id, input logic [31:0] sec,
                             input logic [29:0] nsec, input logic [63:0] now);
        predict_item(kind, id, sec, nsec, now);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, now, nsec, sec, id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop sending and let every expected word drain
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    // setup and access phase; only called while the block is idle
    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == IDX_FREQ)
            tick_rate = value;
    endtask

    // mostly well-formed traffic around a running clock, some pure noise
    task automatic random_items(input int count);
        int          pick;
        logic [31:0] sec;
        logic [29:0] nsec;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)), $urandom(),
                          30'($urandom()), {$urandom(), $urandom()});
            else if (pick < 58)
            begin
                // long sleepers pile up and fill the table
                sec  = ($urandom_range(99) < 8) ? 32'($urandom_range(3, 1)) : 32'd0;
                nsec = 30'($urandom_range(2000000));
                send_item(KIND_SLEEP, 8'($urandom_range(255)), sec, nsec, task_clock);
            end
            else
            begin
                task_clock = task_clock + sleep_ticks(32'd0, 30'($urandom_range(600000)))
                             + 64'($urandom_range(3));
                send_item(KIND_TICK, 8'($urandom_range(255)), 32'($urandom()),
                          30'($urandom()), task_clock);
            end
            if (n % 25 == 24)
                wait_for_results();
        end
        wait_for_results();
    endtask

    // corner cases at the reset tick rate
    task automatic test_directed();
        logic [7:0] id;
        // zero delay, sub-tick delay, wrapped delay, empty table
        send_item(KIND_SLEEP, 8'hFF, 32'd0, 30'd0, 64'd0);
        send_item(KIND_SLEEP, 8'h11, 32'd0, 30'd99, 64'd500);
        send_item(KIND_SLEEP, 8'h00, 32'd1, 30'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_TICK, 8'h00, 32'd0, 30'd0, 64'd0);
        // fill every slot; slot i is due at 1000 + (16-i)*10, but slot 7 far later
        for (int i = 0; i < SLOTS; i++)
        begin
            id = (i == 5) ? 8'(4 * 17) : 8'(i * 17);
            if (i == 7)
                send_item(KIND_SLEEP, id, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 64'd1000);
            else
                send_item(KIND_SLEEP, id, 32'd0, 30'((SLOTS - i) * 1000), 64'd1000);
        end
        send_item(KIND_SLEEP, 8'h3C, 32'd0, 30'd5000, 64'd1000);
        // wakes the upper half in slot order, then refill the lowest hole
        send_item(KIND_TICK, 8'h00, 32'd0, 30'd0, 64'd1080);
        send_item(KIND_SLEEP, 8'hA5, 32'd0, 30'd100, 64'd1080);
        send_item(KIND_TICK, 8'h00, 32'd0, 30'd0, 64'd1081);
        send_item(KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_for_results();
    endtask

    // sweep the tick rate: both ends of the range and a slow clock
    task automatic test_tick_rates();
        logic [31:0] rates [5];
        rates[0] = 32'd100000;
        rates[1] = 32'hFFFF_FFFF;
        rates[2] = 32'd50000;
        rates[3] = 32'd1;
        rates[4] = 32'($urandom_range(32'hFFFF_FFFF, 100000));
        foreach (rates[r])
        begin
            apb_write(IDX_FREQ, rates[r]);
            if (r == 1)
                apb_write(IDX_UNUSED, $urandom());
            random_items(8);
        end
    endtask

    task automatic test_random_sender_heavy();
        apb_write(IDX_FREQ, FREQ_RESET);
        task_clock = {$urandom(), $urandom()} >> 2;
        random_items(75);
    endtask

    task automatic test_random_receiver_heavy();
        apb_write(IDX_FREQ, 32'($urandom_range(50000000, 100000)));
        task_clock = {$urandom(), $urandom()};
        random_items(75);
    endtask

    // clock just below the 64-bit wrap at the highest rate
    task automatic test_random_wrap();
        apb_write(IDX_FREQ, 32'hFFFF_FFFF);
        task_clock = 64'd0 - 64'($urandom_range(20000000));
        random_items(75);
    endtask

    // result checker
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata, m_axis_tlast};
            if (outcome_q.size() == 0)
            begin
                $display("%0t: unexpected word: status %0d id %0d last %0d",
                         $time, got.status, got.id, got.last);
                errors++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch: expected status %0d id %0d last %0d, got status %0d id %0d last %0d",
                             $time, want.status, want.id, want.last,
                             got.status, got.id, got.last);
                    errors++;
                end
            end
        end
    end

    // result stream back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    // watchdog on cycles with no transfer on any port
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sleep_timer_wakeup_table_test failed");
            $finish;
        end
    end

    initial
    begin
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_gap_pct    = 14;
        sink_stall_pct = 76;
        test_directed();
        test_tick_rates();
        test_random_sender_heavy();

        src_gap_pct    = 76;
        sink_stall_pct = 14;
        test_random_receiver_heavy();

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_wrap();

        wait_for_results();
        repeat (SLOTS + 8) @(posedge clk);
        if (errors == 0)
            $display("sleep_timer_wakeup_table_test passed");
        else
            $display("sleep_timer_wakeup_table_test failed");
        $finish;
    end

endmodule
